[sv/cie76_pkg.sv]
// shared constants, types and the linear-segment table of the cie76 block
// no dependencies
`default_nettype none

package cie76_pkg;

    // input format and companding result format
    localparam int IN_W     = 16;
    localparam int IN_FRAC  = 14;
    localparam int F_FRAC   = 16;
    localparam int F_W      = 17;
    localparam int LANES    = 6;

    // cube root pipeline
    localparam int CB_BITS  = 17;
    localparam int CB_SHIFT = 3 * F_FRAC - IN_FRAC;
    localparam int CUBE_W   = IN_W + CB_SHIFT + 2;
    localparam int SQ_W     = 2 * CB_BITS;

    // linear segment below 216/24389
    localparam int LIN_IW   = 8;
    localparam int LIN_N    = 2 ** LIN_IW;
    localparam int LIN_MAX  = (216 << IN_FRAC) / 24389;
    localparam longint LIN_DEN = longint'(3132) << IN_FRAC;

    // lab and distance path
    localparam int RAW_W    = 28;
    localparam int LAB_W    = 20;
    localparam int LAB_MAX  = 2 ** (LAB_W - 1) - 1;
    localparam int DIFF_W   = LAB_W + 1;
    localparam int DSQ_W    = 2 * DIFF_W;
    localparam int SUM_W    = DSQ_W + 2;
    localparam int RT_IN_W  = 40;
    localparam int RT_BITS  = 20;
    localparam int RT_W     = 2 * RT_BITS + 1;
    localparam int OUT_W    = 16;

    localparam int LANE_LAT  = CB_BITS + 1;
    localparam int MERGE_LAT = RT_BITS + 5;
    localparam int LATENCY   = LANE_LAT + MERGE_LAT;

    typedef logic [IN_W-1:0] t_comp;
    typedef logic [F_W-1:0]  t_f;
    typedef logic [LIN_N-1:0][F_W-1:0] t_lin_tbl;

    // (24389/27 * x + 16) / 116 in q.16, rounded, for each small input code
    function automatic t_lin_tbl lin_tbl_init();
        t_lin_tbl t;
        longint   num;
        for (int i = 0; i < LIN_N; i++) begin
            num  = ((longint'(i) * 24389) << F_FRAC) + (longint'(432) << (F_FRAC + IN_FRAC));
            t[i] = F_W'((num + LIN_DEN / 2) / LIN_DEN);
        end
        return t;
    endfunction

    localparam t_lin_tbl LIN_TBL = lin_tbl_init();

endpackage

`default_nettype wire

[sv/cie76_cbrt_lane.sv]
// one companding lane: bit-serial pipelined cube root plus linear-segment table
// depends on cie76_pkg
`default_nettype none

module cie76_cbrt_lane import cie76_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_vld,
    input  wire t_comp i_v,
    output logic       o_vld,
    output t_f         o_f
);

    t_comp                r_v   [1:CB_BITS];
    logic [CB_BITS-1:0]   r_r   [1:CB_BITS];
    logic [SQ_W-1:0]      r_sq  [1:CB_BITS];
    logic [CUBE_W-1:0]    r_cu  [1:CB_BITS];
    logic [CB_BITS:1]     r_vld;
    logic                 r_fvld;
    t_f                   r_f;

    for (genvar k = 0; k < CB_BITS; k++) begin : g_stage
        localparam int B = CB_BITS - 1 - k;
        t_comp              s_v;
        logic [CB_BITS-1:0] s_r;
        logic [SQ_W-1:0]    s_sq;
        logic [CUBE_W-1:0]  s_cu;
        logic               s_vld;
        logic [CUBE_W-1:0]  n_cu;
        logic [SQ_W-1:0]    n_sq;
        logic               n_take;

        if (k == 0) begin : g_first
            assign s_v   = i_v;
            assign s_r   = '0;
            assign s_sq  = '0;
            assign s_cu  = '0;
            assign s_vld = i_vld;
        end else begin : g_rest
            assign s_v   = r_v[k];
            assign s_r   = r_r[k];
            assign s_sq  = r_sq[k];
            assign s_cu  = r_cu[k];
            assign s_vld = r_vld[k];
        end

        // (r + 2^b)^3 from running r^2 and r^3
        always_comb begin
            n_cu = s_cu
                 + (CUBE_W'(s_sq) << (B + 1)) + (CUBE_W'(s_sq) << B)
                 + (CUBE_W'(s_r) << (2 * B + 1)) + (CUBE_W'(s_r) << (2 * B))
                 + (CUBE_W'(1) << (3 * B));
            n_sq = s_sq + (SQ_W'(s_r) << (B + 1)) + (SQ_W'(1) << (2 * B));
            n_take = n_cu <= (CUBE_W'(s_v) << CB_SHIFT);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= s_vld;
            end
            r_v[k+1] <= s_v;
            if (n_take) begin
                r_r[k+1]  <= s_r | (CB_BITS'(1) << B);
                r_sq[k+1] <= n_sq;
                r_cu[k+1] <= n_cu;
            end else begin
                r_r[k+1]  <= s_r;
                r_sq[k+1] <= s_sq;
                r_cu[k+1] <= s_cu;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= 1'b0;
        end else begin
            r_fvld <= r_vld[CB_BITS];
        end
        if (r_v[CB_BITS] > IN_W'(LIN_MAX)) begin
            r_f <= F_W'(r_r[CB_BITS]);
        end else begin
            r_f <= LIN_TBL[r_v[CB_BITS][LIN_IW-1:0]];
        end
    end

    assign o_vld = r_fvld;
    assign o_f   = r_f;

endmodule

`default_nettype wire

[sv/cie76_isqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on cie76_pkg
`default_nettype none

module cie76_isqrt import cie76_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [RT_IN_W-1:0] i_n,
    output logic                    o_vld,
    output logic [RT_BITS-1:0]      o_r
);

    logic [RT_IN_W-1:0] r_n  [1:RT_BITS];
    logic [RT_BITS-1:0] r_r  [1:RT_BITS];
    logic [RT_W-2:0]    r_sq [1:RT_BITS];
    logic [RT_BITS:1]   r_vld;

    for (genvar k = 0; k < RT_BITS; k++) begin : g_stage
        localparam int B = RT_BITS - 1 - k;
        logic [RT_IN_W-1:0] s_n;
        logic [RT_BITS-1:0] s_r;
        logic [RT_W-2:0]    s_sq;
        logic               s_vld;
        logic [RT_W-1:0]    n_sq;
        logic               n_take;

        if (k == 0) begin : g_first
            assign s_n   = i_n;
            assign s_r   = '0;
            assign s_sq  = '0;
            assign s_vld = i_vld;
        end else begin : g_rest
            assign s_n   = r_n[k];
            assign s_r   = r_r[k];
            assign s_sq  = r_sq[k];
            assign s_vld = r_vld[k];
        end

        always_comb begin
            n_sq   = RT_W'(s_sq) + (RT_W'(s_r) << (B + 1)) + (RT_W'(1) << (2 * B));
            n_take = n_sq <= RT_W'(s_n);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= s_vld;
            end
            r_n[k+1] <= s_n;
            if (n_take) begin
                r_r[k+1]  <= s_r | (RT_BITS'(1) << B);
                r_sq[k+1] <= n_sq[RT_W-2:0];
            end else begin
                r_r[k+1]  <= s_r;
                r_sq[k+1] <= s_sq;
            end
        end
    end

    assign o_vld = r_vld[RT_BITS];
    assign o_r   = r_r[RT_BITS];

endmodule

`default_nettype wire

[sv/cie76_merge.sv]
// merging stage: lab from six lane results, squared differences, root and rounding
// depends on cie76_pkg and cie76_isqrt
`default_nettype none

module cie76_merge import cie76_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire t_f               i_f [LANES],
    output logic                  o_vld,
    output logic [OUT_W-1:0]      o_delta_e
);

    logic signed [RAW_W-1:0] r_raw [LANES];
    logic signed [LAB_W-1:0] r_lab [LANES];
    logic [DSQ_W-1:0]        r_dsq [3];
    logic [SUM_W-1:0]        r_sum;
    logic [3:0]              r_vld;
    logic                    r_ovld;
    logic [OUT_W-1:0]        r_out;
    logic                    rt_vld;
    logic [RT_BITS-1:0]      rt_r;
    logic [RT_BITS:0]        rt_half;

    // divide by 256, ties away from zero, saturate to q12.8
    function automatic logic signed [LAB_W-1:0] to_q8(input logic signed [RAW_W-1:0] v);
        logic [RAW_W-1:0] mag;
        logic [RAW_W-1:0] q;
        logic [LAB_W-1:0] res;
        mag = v[RAW_W-1] ? RAW_W'(-v) : RAW_W'(v);
        q   = (mag + RAW_W'(128)) >> 8;
        if (!v[RAW_W-1]) begin
            res = (q > RAW_W'(LAB_MAX)) ? LAB_W'(LAB_MAX) : LAB_W'(q);
        end else begin
            res = (q > RAW_W'(LAB_MAX + 1)) ? LAB_W'(LAB_MAX + 1) : LAB_W'(RAW_W'(0) - q);
        end
        return signed'(res);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[2:0], i_vld};
            r_ovld <= rt_vld;
        end
    end

    for (genvar c = 0; c < 2; c++) begin : g_color
        logic signed [RAW_W-1:0] s_fx, s_fy, s_fz;
        assign s_fx = signed'(RAW_W'(i_f[3*c]));
        assign s_fy = signed'(RAW_W'(i_f[3*c+1]));
        assign s_fz = signed'(RAW_W'(i_f[3*c+2]));
        always_ff @(posedge i_clk) begin
            r_raw[3*c]   <= s_fy * 28'sd116 - 28'sd1048576;
            r_raw[3*c+1] <= (s_fx - s_fy) * 28'sd500;
            r_raw[3*c+2] <= (s_fy - s_fz) * 28'sd200;
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_round
        always_ff @(posedge i_clk) begin
            r_lab[i] <= to_q8(r_raw[i]);
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_diff
        logic signed [DIFF_W-1:0] s_d;
        logic [DIFF_W-1:0]        s_m;
        assign s_d = DIFF_W'(r_lab[j]) - DIFF_W'(r_lab[3+j]);
        assign s_m = s_d[DIFF_W-1] ? DIFF_W'(-s_d) : DIFF_W'(s_d);
        always_ff @(posedge i_clk) begin
            r_dsq[j] <= DSQ_W'(s_m) * DSQ_W'(s_m);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= SUM_W'(r_dsq[0]) + SUM_W'(r_dsq[1]) + SUM_W'(r_dsq[2]);
    end

    cie76_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[3]),
        .i_n     (RT_IN_W'(r_sum >> 4)),
        .o_vld   (rt_vld),
        .o_r     (rt_r)
    );

    // root is in q.6, round to q.5
    assign rt_half = ((RT_BITS + 1)'(rt_r) + (RT_BITS + 1)'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        if (rt_half > (RT_BITS + 1)'(2 ** OUT_W - 1)) begin
            r_out <= '1;
        end else begin
            r_out <= rt_half[OUT_W-1:0];
        end
    end

    assign o_vld     = r_ovld;
    assign o_delta_e = r_out;

endmodule

`default_nettype wire

[sv/cie76_color_difference.sv]
// top level: cie76 color difference between two xyz colors
// depends on cie76_pkg, cie76_cbrt_lane and cie76_merge
//
//   channel   handshake        payload
//   input     start / busy     i_first_x/y/z, i_second_x/y/z (unsigned q2.14)
//   result    o_strobe         o_delta_e (unsigned q11.5, saturating)
//
// one transfer per clock; busy is never raised
// pipeline: 17 cube root stages plus table select in each of six lanes,
// then lab, round, square, sum, 20 square root stages and output rounding
// synchronous active low reset clears all valid flags, payload registers are not reset
// the receiver cannot stall, a result is on o_delta_e for the single o_strobe cycle
`default_nettype none

module cie76_color_difference import cie76_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [IN_W-1:0]  i_first_x,
    input  wire logic [IN_W-1:0]  i_first_y,
    input  wire logic [IN_W-1:0]  i_first_z,
    input  wire logic [IN_W-1:0]  i_second_x,
    input  wire logic [IN_W-1:0]  i_second_y,
    input  wire logic [IN_W-1:0]  i_second_z,
    output logic                  o_strobe,
    output logic [OUT_W-1:0]      o_delta_e
);

    t_comp            comp     [LANES];
    t_f               lane_f   [LANES];
    logic [LANES-1:0] lane_vld;
    logic             in_xfer;

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    assign comp[0] = i_first_x;
    assign comp[1] = i_first_y;
    assign comp[2] = i_first_z;
    assign comp[3] = i_second_x;
    assign comp[4] = i_second_y;
    assign comp[5] = i_second_z;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        cie76_cbrt_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (in_xfer),
            .i_v     (comp[i]),
            .o_vld   (lane_vld[i]),
            .o_f     (lane_f[i])
        );
    end

    cie76_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (lane_vld[0]),
        .i_f       (lane_f),
        .o_vld     (o_strobe),
        .o_delta_e (o_delta_e)
    );

    // all lanes run in lockstep
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_vld == '0) || (lane_vld == '1))
        else $error("companding lanes out of step");

    // every result comes from a transfer a fixed latency earlier
    a_strobe_from_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(in_xfer, LATENCY))
        else $error("result strobe without matching input transfer");

    a_lane_from_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_vld[0] |-> $past(in_xfer, LANE_LAT))
        else $error("lane result without matching input transfer");

endmodule

`default_nettype wire
